@@ rtl/dwsp_pkg.sv @@
// Shared constants for the dual wheel speed PID block.
// Used by the top level, the serial multiplier, the serial divider and the checker.
package dwsp_pkg;

  // serial arithmetic units
  localparam int MUL_AW = 32;
  localparam int MUL_BW = 32;
  localparam int MUL_PW = 64;
  localparam int DIV_NW = 56;
  localparam int DIV_DW = 19;

  // configuration port
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 16;

  localparam logic [CFG_IW-1:0] CFG_KP    = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_KI    = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_KD    = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_FW    = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_ILIM  = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_FLOOR = 3'd5;
  localparam logic [CFG_IW-1:0] CFG_TMO   = 3'd6;
  localparam logic [CFG_IW-1:0] CFG_RAMP  = 3'd7;

  localparam logic [15:0] KP_RST    = 16'd4608;
  localparam logic [15:0] KI_RST    = 16'd1536;
  localparam logic [15:0] KD_RST    = 16'd31;
  localparam logic [8:0]  FW_RST    = 9'd102;
  localparam logic [11:0] ILIM_RST  = 12'd200;
  localparam logic [9:0]  FLOOR_RST = 10'd380;
  localparam logic [9:0]  TMO_RST   = 10'd50;
  localparam logic [9:0]  RAMP_RST  = 10'd5;

  // direction codes
  localparam logic [1:0] DIR_STOP = 2'd0;
  localparam logic [1:0] DIR_FWD  = 2'd1;
  localparam logic [1:0] DIR_REV  = 2'd2;

  // fixed-point scale factors
  localparam int TGT_K     = 3081;
  localparam int SPD_K     = 96000;
  localparam int PPR_L     = 10800;
  localparam int PPR_R     = 11330;
  localparam int BODY_V_K  = 6970;
  localparam int BODY_W_K  = 77446;
  localparam int DRV_DEN   = 409600;
  localparam int IDLE_MAX  = 2047;
  localparam int DUTY_MAX  = 1023;

endpackage

@@ rtl/dual_wheel_speed_pid.sv @@
// Dual wheel speed PID: top level with control sequencer and per-wheel state.
// Depends on dwsp_pkg, dwsp_smul and dwsp_sdiv.
//
// Usage:
//  Input channel (in_valid / in_stall): a beat with in_cmd = 0 loads the linear
//  and angular targets and clears the idle count; it makes no result. A beat
//  with in_cmd = 1 is a control tick carrying both encoder counts; it makes
//  exactly one result beat on the output channel. One shared bit-serial
//  multiplier does sixteen products per tick (fourteen when stopped), each
//  stepping through the bits of its constant or gain operand up to the highest
//  set bit; one 56-step restoring divider does four quotients per tick.
//  One tick is worked on at a time; in_stall is high while it runs.
//  Output channel (out_valid / out_stall): the result sits in an output
//  register. A tick that finishes while the previous result is still stalled
//  waits for that beat to go; a new input beat is taken once the finished
//  result is in the output register, even if it is still stalled.
//  Configuration (cfg_we / cfg_index / cfg_data): one register written per
//  cycle; only while the block is idle, which the user (not the block) ensures.
//  Reset (rst_n low, synchronous): registers go to their defaults, targets,
//  filters, integrators and encoder history clear, out_valid drops.
module dual_wheel_speed_pid (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_cmd,
  input  logic signed [12:0]            in_lin_vel,
  input  logic signed [15:0]            in_ang_vel,
  input  logic signed [31:0]            in_count_left,
  input  logic signed [31:0]            in_count_right,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [9:0]                    out_duty_left,
  output logic [1:0]                    out_dir_left,
  output logic [9:0]                    out_duty_right,
  output logic [1:0]                    out_dir_right,
  output logic signed [19:0]            out_speed_left,
  output logic signed [19:0]            out_speed_right,
  output logic signed [15:0]            out_body_speed,
  output logic signed [15:0]            out_body_turn,
  output logic                          out_stopped,
  input  logic                          cfg_we,
  input  logic [dwsp_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [dwsp_pkg::CFG_DW-1:0]   cfg_data
);

  localparam int MAW = dwsp_pkg::MUL_AW;
  localparam int MBW = dwsp_pkg::MUL_BW;
  localparam int MPW = dwsp_pkg::MUL_PW;
  localparam int DNW = dwsp_pkg::DIV_NW;
  localparam int DDW = dwsp_pkg::DIV_DW;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_RAMP = 4'd1;
  localparam logic [3:0] ST_TGT  = 4'd2;
  localparam logic [3:0] ST_CNT  = 4'd3;
  localparam logic [3:0] ST_SPD  = 4'd4;
  localparam logic [3:0] ST_FW   = 4'd5;
  localparam logic [3:0] ST_FO   = 4'd6;
  localparam logic [3:0] ST_ERR  = 4'd7;
  localparam logic [3:0] ST_KP   = 4'd8;
  localparam logic [3:0] ST_KI   = 4'd9;
  localparam logic [3:0] ST_KD   = 4'd10;
  localparam logic [3:0] ST_DRV  = 4'd11;
  localparam logic [3:0] ST_BV   = 4'd12;
  localparam logic [3:0] ST_BW   = 4'd13;
  localparam logic [3:0] ST_OUT  = 4'd14;

  function automatic logic [31:0] mag32(input logic signed [31:0] x);
    mag32 = x[31] ? 32'(-x) : 32'(x);
  endfunction

  function automatic logic signed [15:0] sat16(input logic neg, input logic [31:0] m);
    logic [31:0] nm;
    nm = -m;
    if (neg) sat16 = (m > 32'd32768) ? 16'sh8000 : nm[15:0];
    else     sat16 = (m > 32'd32767) ? 16'sh7fff : m[15:0];
  endfunction

  function automatic logic signed [19:0] sat20(input logic neg, input logic [DNW-1:0] m);
    logic [DNW-1:0] nm;
    nm = -m;
    if (neg) sat20 = (m > DNW'(524288)) ? 20'sh80000 : nm[19:0];
    else     sat20 = (m > DNW'(524287)) ? 20'sh7ffff : m[19:0];
  endfunction

  // configuration registers
  logic [15:0] kp_r, ki_r, kd_r;
  logic [8:0]  fw_r;
  logic [11:0] ilim_r;
  logic [9:0]  floor_r, tmo_r, ramp_r;

  // controller state
  logic [3:0]         state_r;
  logic               go_r;
  logic               wh_r;
  logic signed [12:0] tl_r, rl_r;
  logic signed [15:0] ta_r, ra_r;
  logic [10:0]        idle_r;
  logic [31:0]        cl_r, cr_r;
  logic [31:0]        pc_r [2];
  logic signed [19:0] fs_r [2];
  logic signed [23:0] is_r [2];
  logic signed [23:0] pe_r [2];

  // per-tick working registers
  logic               stop_r;
  logic signed [17:0] tgt_r;
  logic [DNW-1:0]     cntp_r;
  logic               dneg_r;
  logic signed [19:0] smp_r;
  logic signed [29:0] facc_r;
  logic signed [21:0] e_r;
  logic signed [23:0] s_r;
  logic signed [55:0] nacc_r;
  logic [9:0]         duty_s_r [2];
  logic [1:0]         dir_s_r [2];
  logic signed [15:0] bv_r, bw_r;

  // output register
  logic               out_valid_r;
  logic [9:0]         out_duty_l_r, out_duty_r_r;
  logic [1:0]         out_dir_l_r, out_dir_r_r;
  logic signed [19:0] out_spd_l_r, out_spd_r_r;
  logic signed [15:0] out_bv_r, out_bw_r;
  logic               out_stop_r;

  // combinational
  logic [31:0]        cnt_i, pc_i, diff;
  logic signed [19:0] f_i;
  logic signed [23:0] is_i, pe_i;
  logic [8:0]         w_eff, wc;
  logic signed [21:0] v_lin, v_ang, v_i;
  logic [10:0]        idle_inc;
  logic               stop_now;
  logic signed [13:0] dl, rsl, dcl;
  logic signed [16:0] da, rsa, dca;
  logic signed [21:0] e_n;
  logic signed [24:0] ssum, limp;
  logic [22:0]        lim;
  logic signed [23:0] s_n, de;
  logic [22:0]        kp100;
  logic [29:0]        kd10k;
  logic signed [20:0] fsum_b, fdif_b;
  logic [MAW-1:0]     mul_a;
  logic [MBW-1:0]     mul_b;
  logic               mul_neg, mul_start, mul_done;
  logic [MPW-1:0]     mul_p;
  logic [DNW-1:0]     div_n, div_q;
  logic [DDW-1:0]     div_d;
  logic               div_start, div_done;
  logic signed [63:0] prod_s;
  logic [63:0]        rnd16;
  logic [17:0]        t18;
  logic signed [29:0] fsum;
  logic [29:0]        fmag, frnd;
  logic signed [19:0] fnew;
  logic [10:0]        dsum;
  logic [9:0]         duty_n;
  logic [1:0]         dir_n;
  logic               is_mul, is_div, slot_free;

  assign cnt_i = wh_r ? cr_r : cl_r;
  assign pc_i  = pc_r[wh_r];
  assign f_i   = fs_r[wh_r];
  assign is_i  = is_r[wh_r];
  assign pe_i  = pe_r[wh_r];
  assign diff  = cnt_i - pc_i;

  assign w_eff = (fw_r > 9'd256) ? 9'd256 : fw_r;
  assign wc    = 9'd256 - w_eff;

  assign v_lin = $signed({{9{rl_r[12]}}, rl_r}) * 22'sd100;
  assign v_ang = $signed({{6{ra_r[15]}}, ra_r}) * 22'sd9;
  assign v_i   = wh_r ? (v_lin + v_ang) : (v_lin - v_ang);

  assign idle_inc = (idle_r == 11'(dwsp_pkg::IDLE_MAX)) ? idle_r : idle_r + 11'd1;
  assign stop_now = (idle_inc > {1'b0, tmo_r});

  // ramp limiter for both targets
  assign dl  = 14'(tl_r) - 14'(rl_r);
  assign rsl = $signed({4'b0, ramp_r});
  assign dcl = (dl > rsl) ? rsl : ((dl < -rsl) ? -rsl : dl);
  assign da  = 17'(ta_r) - 17'(ra_r);
  assign rsa = $signed({7'b0, ramp_r});
  assign dca = (da > rsa) ? rsa : ((da < -rsa) ? -rsa : da);

  // error and clamped integral
  assign e_n  = 22'(tgt_r) - 22'(f_i);
  assign ssum = 25'(is_i) + 25'(e_n);
  assign lim  = 23'(ilim_r) * 23'd1600;
  assign limp = $signed({2'b0, lim});
  assign s_n  = (ssum > limp) ? 24'(limp) : ((ssum < -limp) ? 24'(-limp) : 24'(ssum));
  assign de   = 24'(e_r) - pe_i;

  assign kp100 = 23'(kp_r) * 23'd100;
  assign kd10k = 30'(kd_r) * 30'd10000;

  assign fsum_b = 21'(fs_r[0]) + 21'(fs_r[1]);
  assign fdif_b = 21'(fs_r[1]) - 21'(fs_r[0]);

  assign is_mul = (state_r == ST_TGT) || (state_r == ST_CNT) || (state_r == ST_FW)
               || (state_r == ST_FO) || (state_r == ST_KP) || (state_r == ST_KI)
               || (state_r == ST_KD) || (state_r == ST_BV) || (state_r == ST_BW);
  assign is_div = (state_r == ST_SPD) || (state_r == ST_DRV);

  assign mul_start = is_mul && !go_r && !((state_r == ST_TGT) && stop_r);
  assign div_start = is_div && !go_r;

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    case (state_r)
      ST_TGT: begin
        mul_a = mag32(32'(v_i)); mul_b = MBW'(dwsp_pkg::TGT_K); mul_neg = v_i[21];
      end
      ST_CNT: begin
        mul_a = mag32(diff); mul_b = MBW'(dwsp_pkg::SPD_K); mul_neg = diff[31];
      end
      ST_FW: begin
        mul_a = mag32(32'(smp_r)); mul_b = MBW'(w_eff); mul_neg = smp_r[19];
      end
      ST_FO: begin
        mul_a = mag32(32'(f_i)); mul_b = MBW'(wc); mul_neg = f_i[19];
      end
      ST_KP: begin
        mul_a = mag32(32'(e_r)); mul_b = MBW'(kp100); mul_neg = e_r[21];
      end
      ST_KI: begin
        mul_a = mag32(32'(s_r)); mul_b = MBW'(ki_r); mul_neg = s_r[23];
      end
      ST_KD: begin
        mul_a = mag32(32'(de)); mul_b = MBW'(kd10k); mul_neg = de[23];
      end
      ST_BV: begin
        mul_a = mag32(32'(fsum_b)); mul_b = MBW'(dwsp_pkg::BODY_V_K); mul_neg = fsum_b[20];
      end
      ST_BW: begin
        mul_a = mag32(32'(fdif_b)); mul_b = MBW'(dwsp_pkg::BODY_W_K); mul_neg = fdif_b[20];
      end
      default: begin
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
      end
    endcase
  end

  always_comb begin
    div_n = '0;
    div_d = '0;
    case (state_r)
      ST_SPD: begin
        // bias by half the divisor: round half away from zero on the magnitude
        div_n = wh_r ? cntp_r + DNW'(dwsp_pkg::PPR_R / 2) : cntp_r + DNW'(dwsp_pkg::PPR_L / 2);
        div_d = wh_r ? DDW'(dwsp_pkg::PPR_R) : DDW'(dwsp_pkg::PPR_L);
      end
      ST_DRV: begin
        div_n = nacc_r[55] ? DNW'(-nacc_r) : DNW'(nacc_r);
        div_d = DDW'(dwsp_pkg::DRV_DEN);
      end
      default: begin
        div_n = '0;
        div_d = '0;
      end
    endcase
  end

  dwsp_smul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  dwsp_sdiv u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .n     (div_n),
    .d     (div_d),
    .done  (div_done),
    .q     (div_q)
  );

  assign prod_s = mul_neg ? -$signed(mul_p) : $signed(mul_p);
  assign rnd16  = mul_p + 64'd32768;
  assign t18    = {1'b0, rnd16[32:16]};

  // filter: round half away from zero on /256
  assign fsum = facc_r + prod_s[29:0];
  assign fmag = fsum[29] ? 30'(-fsum) : 30'(fsum);
  assign frnd = (fmag + 30'd128) >> 8;
  assign fnew = fsum[29] ? -$signed(frnd[19:0]) : $signed(frnd[19:0]);

  assign dsum   = {1'b0, div_q[9:0]} + {1'b0, floor_r};
  assign duty_n = (div_q == '0) ? 10'd0
                : (div_q > DNW'(dwsp_pkg::DUTY_MAX)) ? 10'(dwsp_pkg::DUTY_MAX)
                : (dsum > 11'(dwsp_pkg::DUTY_MAX)) ? 10'(dwsp_pkg::DUTY_MAX) : dsum[9:0];
  assign dir_n  = (nacc_r == '0) ? dwsp_pkg::DIR_STOP
                : (nacc_r[55] ? dwsp_pkg::DIR_REV : dwsp_pkg::DIR_FWD);

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r        <= dwsp_pkg::KP_RST;
      ki_r        <= dwsp_pkg::KI_RST;
      kd_r        <= dwsp_pkg::KD_RST;
      fw_r        <= dwsp_pkg::FW_RST;
      ilim_r      <= dwsp_pkg::ILIM_RST;
      floor_r     <= dwsp_pkg::FLOOR_RST;
      tmo_r       <= dwsp_pkg::TMO_RST;
      ramp_r      <= dwsp_pkg::RAMP_RST;
      state_r     <= ST_IDLE;
      go_r        <= 1'b0;
      wh_r        <= 1'b0;
      tl_r        <= '0;
      ta_r        <= '0;
      rl_r        <= '0;
      ra_r        <= '0;
      idle_r      <= '0;
      pc_r[0]     <= '0;
      pc_r[1]     <= '0;
      fs_r[0]     <= '0;
      fs_r[1]     <= '0;
      is_r[0]     <= '0;
      is_r[1]     <= '0;
      pe_r[0]     <= '0;
      pe_r[1]     <= '0;
      stop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          dwsp_pkg::CFG_KP:    kp_r    <= cfg_data;
          dwsp_pkg::CFG_KI:    ki_r    <= cfg_data;
          dwsp_pkg::CFG_KD:    kd_r    <= cfg_data;
          dwsp_pkg::CFG_FW:    fw_r    <= cfg_data[8:0];
          dwsp_pkg::CFG_ILIM:  ilim_r  <= cfg_data[11:0];
          dwsp_pkg::CFG_FLOOR: floor_r <= cfg_data[9:0];
          dwsp_pkg::CFG_TMO:   tmo_r   <= cfg_data[9:0];
          dwsp_pkg::CFG_RAMP:  ramp_r  <= cfg_data[9:0];
          default: ;
        endcase
      end

      // set when the sequencer hands over a result, clear once the beat is taken
      if ((state_r == ST_OUT) && slot_free) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;

      // shared handshake with the serial units: start on entry, advance on done
      if ((is_mul && !((state_r == ST_TGT) && stop_r)) || is_div) begin
        if (!go_r) go_r <= 1'b1;
        else if (mul_done || div_done) go_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            if (!in_cmd) begin
              tl_r   <= in_lin_vel;
              ta_r   <= in_ang_vel;
              idle_r <= '0;
            end else begin
              cl_r    <= in_count_left;
              cr_r    <= in_count_right;
              state_r <= ST_RAMP;
            end
          end
        end
        ST_RAMP: begin
          idle_r <= idle_inc;
          stop_r <= stop_now;
          wh_r   <= 1'b0;
          if (stop_now) begin
            tl_r <= '0;
            ta_r <= '0;
            rl_r <= '0;
            ra_r <= '0;
          end else begin
            rl_r <= 13'(14'(rl_r) + dcl);
            ra_r <= 16'(17'(ra_r) + dca);
          end
          state_r <= ST_TGT;
        end
        ST_TGT: begin
          if (stop_r) begin
            tgt_r   <= '0;
            state_r <= ST_CNT;
          end else if (go_r && mul_done) begin
            tgt_r   <= mul_neg ? $signed(-t18) : $signed(t18);
            state_r <= ST_CNT;
          end
        end
        ST_CNT: begin
          if (go_r && mul_done) begin
            cntp_r     <= mul_p[DNW-1:0];
            dneg_r     <= mul_neg;
            pc_r[wh_r] <= cnt_i;
            state_r    <= ST_SPD;
          end
        end
        ST_SPD: begin
          if (go_r && div_done) begin
            smp_r   <= sat20(dneg_r, div_q);
            state_r <= ST_FW;
          end
        end
        ST_FW: begin
          if (go_r && mul_done) begin
            facc_r  <= prod_s[29:0];
            state_r <= ST_FO;
          end
        end
        ST_FO: begin
          if (go_r && mul_done) begin
            fs_r[wh_r] <= fnew;
            state_r    <= ST_ERR;
          end
        end
        ST_ERR: begin
          e_r        <= e_n;
          s_r        <= s_n;
          is_r[wh_r] <= s_n;
          nacc_r     <= '0;
          state_r    <= ST_KP;
        end
        ST_KP: begin
          if (go_r && mul_done) begin
            nacc_r  <= nacc_r + prod_s[55:0];
            state_r <= ST_KI;
          end
        end
        ST_KI: begin
          if (go_r && mul_done) begin
            nacc_r  <= nacc_r + prod_s[55:0];
            state_r <= ST_KD;
          end
        end
        ST_KD: begin
          if (go_r && mul_done) begin
            nacc_r     <= nacc_r + prod_s[55:0];
            pe_r[wh_r] <= 24'(e_r);
            state_r    <= ST_DRV;
          end
        end
        ST_DRV: begin
          if (go_r && div_done) begin
            duty_s_r[wh_r] <= duty_n;
            dir_s_r[wh_r]  <= dir_n;
            if (!wh_r) begin
              wh_r    <= 1'b1;
              state_r <= ST_TGT;
            end else begin
              state_r <= ST_BV;
            end
          end
        end
        ST_BV: begin
          if (go_r && mul_done) begin
            bv_r    <= sat16(mul_neg, rnd16[47:16]);
            state_r <= ST_BW;
          end
        end
        ST_BW: begin
          if (go_r && mul_done) begin
            bw_r    <= sat16(mul_neg, rnd16[47:16]);
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (slot_free) begin
            out_duty_l_r <= duty_s_r[0];
            out_dir_l_r  <= dir_s_r[0];
            out_duty_r_r <= duty_s_r[1];
            out_dir_r_r  <= dir_s_r[1];
            out_spd_l_r  <= fs_r[0];
            out_spd_r_r  <= fs_r[1];
            out_bv_r     <= bv_r;
            out_bw_r     <= bw_r;
            out_stop_r   <= stop_r;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_duty_left   = out_duty_l_r;
  assign out_dir_left    = out_dir_l_r;
  assign out_duty_right  = out_duty_r_r;
  assign out_dir_right   = out_dir_r_r;
  assign out_speed_left  = out_spd_l_r;
  assign out_speed_right = out_spd_r_r;
  assign out_body_speed  = out_bv_r;
  assign out_body_turn   = out_bw_r;
  assign out_stopped     = out_stop_r;

endmodule

@@ rtl/dwsp_smul.sv @@
// Bit-serial shift-and-add multiplier, unsigned operands.
// Depends on dwsp_pkg for operand and product widths.
module dwsp_smul (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [dwsp_pkg::MUL_AW-1:0]  a,
  input  logic [dwsp_pkg::MUL_BW-1:0]  b,
  output logic                         done,
  output logic [dwsp_pkg::MUL_PW-1:0]  p
);

  localparam int PW = dwsp_pkg::MUL_PW;

  logic [PW-1:0]                a_r;
  logic [dwsp_pkg::MUL_BW-1:0]  b_r;
  logic [PW-1:0]                p_r;
  logic                         run_r;
  logic                         done_r;

  // one multiplier bit per cycle; stops as soon as no set bits remain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        a_r   <= PW'(a);
        b_r   <= b;
        p_r   <= '0;
        run_r <= 1'b1;
      end else if (run_r) begin
        if (b_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end else begin
          if (b_r[0]) p_r <= p_r + a_r;
          a_r <= a_r << 1;
          b_r <= b_r >> 1;
        end
      end
    end
  end

  assign done = done_r;
  assign p    = p_r;

endmodule

@@ rtl/dwsp_sdiv.sv @@
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on dwsp_pkg for dividend and divisor widths.
module dwsp_sdiv (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [dwsp_pkg::DIV_NW-1:0]  n,
  input  logic [dwsp_pkg::DIV_DW-1:0]  d,
  output logic                         done,
  output logic [dwsp_pkg::DIV_NW-1:0]  q
);

  localparam int NW = dwsp_pkg::DIV_NW;
  localparam int DW = dwsp_pkg::DIV_DW;
  localparam int CW = $clog2(NW);

  logic [NW-1:0] q_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] d_r;
  logic [CW-1:0] cnt_r;
  logic          run_r;
  logic          done_r;
  logic [DW:0]   r2;
  logic [DW:0]   rdif;
  logic          ge;

  assign r2   = {rem_r, q_r[NW-1]};
  assign rdif = r2 - {1'b0, d_r};
  assign ge   = (r2 >= {1'b0, d_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        q_r   <= n;
        d_r   <= d;
        rem_r <= '0;
        cnt_r <= '0;
        run_r <= 1'b1;
      end else if (run_r) begin
        // remainder stays below the divisor, so DW bits hold it
        rem_r <= ge ? rdif[DW-1:0] : r2[DW-1:0];
        q_r   <= {q_r[NW-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(NW - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign q    = q_r;

endmodule

@@ rtl/dwsp_chk.sv @@
// Port-level checker for dual_wheel_speed_pid, bound to the top level.
// Depends on dwsp_pkg for direction codes.
module dwsp_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       in_cmd,
  input logic       out_valid,
  input logic       out_stall,
  input logic [9:0] out_duty_left,
  input logic [1:0] out_dir_left,
  input logic [9:0] out_duty_right,
  input logic [1:0] out_dir_right
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_duty_left) && $stable(out_duty_right))
    else $error("stalled result changed");

  a_stop_no_duty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_dir_left != dwsp_pkg::DIR_STOP || out_duty_left == 10'd0)
               && (out_dir_right != dwsp_pkg::DIR_STOP || out_duty_right == 10'd0))
    else $error("duty nonzero with stop direction");

  a_cmd_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_cmd |=> !in_stall)
    else $error("command beat held the input side");

  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_cmd |=> in_stall)
    else $error("tick beat did not start work");

endmodule

bind dual_wheel_speed_pid dwsp_chk u_dwsp_chk (.*);
